// File: src/cle_pkg.sv
// Shared types and constants for the line editor core.
// Depends on nothing; every other file but cle_ram refers to it, the testbench by import.
`timescale 1ns / 1ps

package cle_pkg;

  // Default depth of the line store, in bytes
  localparam int LINE_DEPTH_DEF = 32;

  // Field widths of the channels and the capacity register
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 5;
  localparam int CAP_W  = 6;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SP,
    S_BS2,
    S_LF,
    S_RD,
    S_END
  } cle_state_t;

endpackage

// File: src/cle_in_if.sv
// Input channel of the line editor: one received byte per item.
// Depends on cle_pkg for the byte width.
`timescale 1ns / 1ps

interface cle_in_if;
  logic                         valid;
  logic                         ready;
  logic [cle_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: src/cle_out_if.sv
// Result channel of the line editor: echo bytes, line bytes and line end markers.
// Depends on cle_pkg for the field widths.
`timescale 1ns / 1ps

interface cle_out_if;
  logic                         valid;
  logic                         ready;
  logic [cle_pkg::KIND_W-1:0]   kind;
  logic [cle_pkg::BYTE_W-1:0]   data;
  logic [cle_pkg::LEN_W-1:0]    line_length;
  logic                         last;

  modport source (output valid, output kind, output data, output line_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input data, input line_length,
                  input last, output ready);
endinterface

// File: src/cle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/cle_ctrl.sv
// Line editor sequencer: decodes received bytes, keeps the line in cle_ram,
// and drives the result register. Depends on cle_pkg, cle_in_if, cle_out_if, cle_ram.
`timescale 1ns / 1ps

module cle_ctrl #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cle_pkg::CAP_W-1:0] capacity,
  cle_in_if.sink                    in_ch,
  cle_out_if.source                 out_ch
);

  localparam int PW    = $clog2(LINE_DEPTH);
  localparam int CMP_W = ((cle_pkg::CAP_W > PW) ? cle_pkg::CAP_W : PW) + 1;

  cle_pkg::cle_state_t state_r, state_nxt;
  logic [PW-1:0]       fill_r, fill_nxt;
  logic [PW-1:0]       rd_r, rd_nxt;
  logic                drop_r, drop_nxt;

  // result register
  logic                        out_valid_r;
  logic [cle_pkg::KIND_W-1:0]  kind_r;
  logic [cle_pkg::BYTE_W-1:0]  data_r;
  logic [cle_pkg::LEN_W-1:0]   len_r;
  logic                        last_r;

  logic                        emit;
  logic [cle_pkg::KIND_W-1:0]  e_kind;
  logic [cle_pkg::BYTE_W-1:0]  e_data;
  logic [cle_pkg::LEN_W-1:0]   e_len;
  logic                        e_last;

  // store ports
  logic                        ram_we;
  logic                        ram_re;
  logic [PW-1:0]               ram_raddr;
  logic [cle_pkg::BYTE_W-1:0]  ram_rdata;

  // decode and limit
  logic                        out_free;
  logic                        accept;
  logic [cle_pkg::BYTE_W-1:0]  ch;
  logic                        is_cr, is_eol, is_bs, swallow;
  logic [CMP_W-1:0]            cap_ext, cap_clip, keep_lim;
  logic                        can_keep;
  logic [PW:0]                 rd_inc;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == cle_pkg::S_IDLE) && out_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign ch = in_ch.rx_byte;

  assign is_cr   = (ch == cle_pkg::CH_CR);
  assign is_eol  = is_cr || (ch == cle_pkg::CH_LF);
  assign is_bs   = (ch == cle_pkg::CH_BS) || (ch == cle_pkg::CH_DEL);
  assign swallow = drop_r && (ch == cle_pkg::CH_LF);

  // bytes kept at most: min(capacity, depth) - 1, none for zero capacity
  assign cap_ext  = CMP_W'(capacity);
  assign cap_clip = (cap_ext > CMP_W'(LINE_DEPTH)) ? CMP_W'(LINE_DEPTH) : cap_ext;
  assign keep_lim = (cap_clip == '0) ? '0 : cap_clip - 1'b1;
  assign can_keep = CMP_W'(fill_r) < keep_lim;

  assign rd_inc = {1'b0, rd_r} + 1'b1;

  // line store; writes happen only on accept in idle and reads only during
  // readout, so the two never touch the same entry in one cycle
  cle_ram #(
    .WIDTH (cle_pkg::BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r),
    .wdata (ch),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cle_pkg::S_IDLE;
      fill_r  <= '0;
      rd_r    <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rd_r    <= rd_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // next state and result selection
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    rd_nxt    = rd_r;
    drop_nxt  = drop_r;
    emit      = 1'b0;
    e_kind    = cle_pkg::KIND_ECHO;
    e_data    = '0;
    e_len     = '0;
    e_last    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rd_r;
    unique case (state_r)
      cle_pkg::S_IDLE: begin
        if (accept) begin
          drop_nxt = 1'b0;
          if (swallow) begin
            // LF right after a CR line end: nothing to do
          end else if (is_eol) begin
            drop_nxt  = is_cr;
            emit      = 1'b1;
            e_data    = cle_pkg::CH_CR;
            state_nxt = cle_pkg::S_LF;
          end else if (is_bs) begin
            if (fill_r != '0) begin
              fill_nxt  = fill_r - 1'b1;
              emit      = 1'b1;
              e_data    = cle_pkg::CH_BS;
              state_nxt = cle_pkg::S_SP;
            end
          end else if (can_keep) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + 1'b1;
            emit     = 1'b1;
            e_data   = ch;
            e_last   = 1'b1;
          end
        end
      end
      cle_pkg::S_SP: begin
        if (out_free) begin
          emit      = 1'b1;
          e_data    = cle_pkg::CH_SP;
          state_nxt = cle_pkg::S_BS2;
        end
      end
      cle_pkg::S_BS2: begin
        if (out_free) begin
          emit      = 1'b1;
          e_data    = cle_pkg::CH_BS;
          e_last    = 1'b1;
          state_nxt = cle_pkg::S_IDLE;
        end
      end
      cle_pkg::S_LF: begin
        if (out_free) begin
          emit   = 1'b1;
          e_data = cle_pkg::CH_LF;
          rd_nxt = '0;
          if (fill_r == '0) begin
            state_nxt = cle_pkg::S_END;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_nxt = cle_pkg::S_RD;
          end
        end
      end
      cle_pkg::S_RD: begin
        // read data was fetched in the previous step and holds while stalled
        if (out_free) begin
          emit   = 1'b1;
          e_kind = cle_pkg::KIND_LINE;
          e_data = ram_rdata;
          rd_nxt = rd_inc[PW-1:0];
          if (rd_inc == {1'b0, fill_r}) begin
            state_nxt = cle_pkg::S_END;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_inc[PW-1:0];
          end
        end
      end
      cle_pkg::S_END: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = cle_pkg::KIND_END;
          e_len     = cle_pkg::LEN_W'(fill_r);
          e_last    = 1'b1;
          fill_nxt  = '0;
          state_nxt = cle_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cle_pkg::S_IDLE;
      end
    endcase
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= e_kind;
      data_r <= e_data;
      len_r  <= e_len;
      last_r <= e_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.data        = data_r;
  assign out_ch.line_length = len_r;
  assign out_ch.last        = last_r;

`ifndef SYNTH
  // fill position never passes the last store entry
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= PW'(LINE_DEPTH - 1))
    else $error("fill position beyond store depth");

  // readout index stays below the fill position
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cle_pkg::S_RD) |-> (rd_r < fill_r))
    else $error("readout index past line end");

  // a line end marker always closes its item
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == cle_pkg::KIND_END) |-> last_r)
    else $error("line end marker without last");

  // an erase on a non-empty line leads into the space echo
  a_bs_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_bs && !swallow && fill_r != '0) |=> (state_r == cle_pkg::S_SP))
    else $error("erase sequence not started");

  // a result is never overwritten while it waits
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(data_r)))
    else $error("waiting result lost");
`endif

endmodule

// File: src/line_editor_echo_crlf_core.sv
// Line editor core for a serial terminal in cooked mode.
//
// in_ch  : one received byte per item (valid/ready).
// out_ch : result items: echo bytes (kind 0), kept line bytes (kind 1) and a
//          line end marker (kind 2) with the line length; last marks the final
//          result caused by one received byte.
// cfg_we / cfg_wdata : writes the line capacity register (reset 32); at most
//          capacity-1 bytes, and at most LINE_DEPTH-1, are kept.
// Timing: every result passes one output register, so the first result of an
//   item appears in the cycle after it is accepted. A kept byte gives one echo
//   result and an ignored byte none. An erase gives three echo results. A
//   line end gives CR, LF, one store read per kept byte through the single
//   read port of the line store, then the end marker.
//   Input is held off until the last result of an item has been loaded.
// Stall: when out_ch.ready is low the waiting result and the sequencer hold;
//   a new byte is taken only once the output register can take its result.
// Reset: synchronous, active low; empties the line, clears the CR flag and
//   the output valid, and loads capacity 32. No clearing pass is needed.
// Depends on cle_pkg, cle_in_if, cle_out_if, cle_ram, cle_ctrl.
`timescale 1ns / 1ps

module line_editor_echo_crlf_core #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cle_pkg::CAP_W-1:0] cfg_wdata,
  cle_in_if.sink                    in_ch,
  cle_out_if.source                 out_ch
);

  logic [cle_pkg::CAP_W-1:0] capacity_r;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= cle_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  cle_ctrl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for line_editor_echo_crlf_core: typed keystroke table, then random lines.
// Depends on cle_pkg, cle_in_if, cle_out_if and the core; all results are checked in order.
`timescale 1ns / 1ps

module testbench;
  import cle_pkg::*;

  localparam int CLK_HALF   = 2;
  localparam int CYC_LIMIT  = 400000;
  localparam int STORE_DEPTH = LINE_DEPTH_DEF;
  localparam int PHASE_ITEMS = 52;
  localparam int QUIET_CYC  = 4;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_t;

  // One terminal output item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } term_item_t;

  // One keystroke row; when typed is set, n_res and the final item are given by hand
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    logic [5:0]        n_res;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } key_row_t;

  localparam int N_ROWS = 24;
  localparam key_row_t KEY_TAB [0:N_ROWS-1] = '{
    '{8'h41,  1'b1, 6'd1, KIND_ECHO, 8'h41, 5'd0},  // printable byte
    '{8'h00,  1'b1, 6'd1, KIND_ECHO, 8'h00, 5'd0},  // lowest byte is kept
    '{8'hFF,  1'b1, 6'd1, KIND_ECHO, 8'hFF, 5'd0},  // highest byte is kept
    '{CH_BS,  1'b1, 6'd3, KIND_ECHO, CH_BS, 5'd0},  // erase echoes BS SP BS
    '{CH_DEL, 1'b1, 6'd3, KIND_ECHO, CH_BS, 5'd0},
    '{CH_DEL, 1'b1, 6'd3, KIND_ECHO, CH_BS, 5'd0},  // line now empty
    '{CH_BS,  1'b1, 6'd0, KIND_ECHO, 8'h00, 5'd0},  // erase on empty line
    '{CH_DEL, 1'b1, 6'd0, KIND_ECHO, 8'h00, 5'd0},
    '{8'h80,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0},
    '{8'h7E,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0},
    '{8'h01,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0},
    '{8'h1B,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0},  // control byte is kept
    '{CH_CR,  1'b1, 6'd7, KIND_END,  8'h00, 5'd4},  // CR LF, 4 bytes, end
    '{CH_LF,  1'b1, 6'd0, KIND_ECHO, 8'h00, 5'd0},  // LF after CR swallowed
    '{CH_LF,  1'b1, 6'd3, KIND_END,  8'h00, 5'd0},  // empty line by LF
    '{CH_CR,  1'b1, 6'd3, KIND_END,  8'h00, 5'd0},
    '{8'h78,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0},  // other byte after CR
    '{CH_CR,  1'b1, 6'd4, KIND_END,  8'h00, 5'd1},
    '{CH_CR,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0},  // CR after CR
    '{CH_LF,  1'b1, 6'd0, KIND_ECHO, 8'h00, 5'd0},
    '{8'h71,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0},
    '{8'h09,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0},
    '{CH_BS,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0},
    '{CH_LF,  1'b0, 6'd0, KIND_ECHO, 8'h00, 5'd0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  cle_in_if  in_ch ();
  cle_out_if out_ch ();

  line_editor_echo_crlf_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Mirror of the editor state
  logic [BYTE_W-1:0] line_mem [0:STORE_DEPTH-1];
  int                fill_pos;
  logic              drop_lf;
  logic [CAP_W-1:0]  cap_reg;

  term_item_t term_out_q [$];
  int         errors;
  int         cycle_cnt;
  int         counted;
  int         src_idle_pct;
  int         snk_stall_pct;
  int         hold_req;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void push_term(input logic [KIND_W-1:0] kind,
                                    input logic [BYTE_W-1:0] data,
                                    input logic [LEN_W-1:0] len);
    term_item_t it;
    it.kind = kind;
    it.data = data;
    it.len  = len;
    it.last = 1'b0;
    term_out_q.push_back(it);
  endfunction

  // Editor response to one keystroke; returns how many output items it makes
  function automatic int edit_keystroke(input logic [BYTE_W-1:0] ch);
    int n;
    int lim;
    n = 0;
    if (drop_lf) begin
      drop_lf = 1'b0;
      if (ch == CH_LF) return 0;
    end
    if (ch == CH_CR || ch == CH_LF) begin
      drop_lf = (ch == CH_CR);
      push_term(KIND_ECHO, CH_CR, '0);
      push_term(KIND_ECHO, CH_LF, '0);
      n = 2;
      for (int i = 0; i < fill_pos; i++) begin
        push_term(KIND_LINE, line_mem[i], '0);
        n++;
      end
      push_term(KIND_END, '0, fill_pos[LEN_W-1:0]);
      n++;
      fill_pos = 0;
    end else if (ch == CH_BS || ch == CH_DEL) begin
      if (fill_pos > 0) begin
        fill_pos--;
        push_term(KIND_ECHO, CH_BS, '0);
        push_term(KIND_ECHO, CH_SP, '0);
        push_term(KIND_ECHO, CH_BS, '0);
        n = 3;
      end
    end else begin
      // capacity counts a terminator; the store depth bounds it too
      lim = (cap_reg > STORE_DEPTH) ? STORE_DEPTH : int'(cap_reg);
      lim = (lim == 0) ? 0 : lim - 1;
      if (fill_pos < lim) begin
        line_mem[fill_pos] = ch;
        fill_pos++;
        push_term(KIND_ECHO, ch, '0);
        n = 1;
      end
    end
    if (n > 0) term_out_q[term_out_q.size()-1].last = 1'b1;
    return n;
  endfunction

  // Offer one keystroke; entered and left at a falling edge
  task automatic send_key(input logic [BYTE_W-1:0] b, output int n);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = edit_keystroke(b);
    counted++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid = 1'b0;
    while (term_out_q.size() != 0) @(negedge clk);
    // ignored keystrokes may still be in flight
    repeat (QUIET_CYC) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    cap_reg   = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte;
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(255));
    while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL)
      b = BYTE_W'($urandom_range(255));
    return b;
  endfunction

  // One line with random content, some erases, and a random terminator
  task automatic send_line;
    int len;
    int r;
    int n;
    if ($urandom_range(9) == 0) len = $urandom_range(40);
    else len = $urandom_range((cap_reg > 33) ? 33 : int'(cap_reg));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 8) send_key(r[0] ? CH_BS : CH_DEL, n);
      else send_key(plain_byte(), n);
    end
    r = $urandom_range(99);
    if (r < 40) send_key(CH_CR, n);
    else if (r < 70) send_key(CH_LF, n);
    else begin
      send_key(CH_CR, n);
      send_key(CH_LF, n);
    end
  endtask

  task automatic set_idle(input idle_mode_t m);
    src_idle_pct  = (m == IDLE_SRC) ? 66 : (m == IDLE_BOTH) ? 34 : 0;
    snk_stall_pct = (m == IDLE_SNK) ? 66 : (m == IDLE_BOTH) ? 34 : 0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input idle_mode_t m,
                           input int hold);
    int n;
    drain();
    write_capacity(cap);
    set_idle(m);
    hold_req = hold;
    counted  = 0;
    while (counted < PHASE_ITEMS) begin
      if ($urandom_range(99) < 20) send_key(BYTE_W'($urandom_range(255)), n);
      else send_line();
    end
  endtask

  // Result side: ready pattern, with an optional long hold-off
  initial begin : sink_side
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Compare every accepted output item with the oldest pending one
  always @(posedge clk) begin : out_check
    term_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (term_out_q.size() == 0) begin
        $error("unexpected item kind=%0d data=%02h line_length=%0d last=%0b",
               out_ch.kind, out_ch.data, out_ch.line_length, out_ch.last);
        errors++;
      end else begin
        want = term_out_q.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          errors++;
        end
        if (out_ch.data !== want.data) begin
          $error("data: expected %02h, got %02h", want.data, out_ch.data);
          errors++;
        end
        if (out_ch.line_length !== want.len) begin
          $error("line_length: expected %0d, got %0d", want.len, out_ch.line_length);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : main_seq
    int n;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    errors        = 0;
    cycle_cnt     = 0;
    counted       = 0;
    hold_req      = 0;
    fill_pos      = 0;
    drop_lf       = 1'b0;
    cap_reg       = CAP_RESET;
    for (int i = 0; i < STORE_DEPTH; i++) line_mem[i] = '0;
    set_idle(IDLE_NONE);
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed keystrokes at reset capacity
    for (int r = 0; r < N_ROWS; r++) begin
      send_key(KEY_TAB[r].rx, n);
      if (KEY_TAB[r].typed) begin
        if (n != int'(KEY_TAB[r].n_res)) begin
          $error("row %0d item count: expected %0d, got %0d", r, KEY_TAB[r].n_res, n);
          errors++;
        end else if (n > 0) begin
          // final item of this row cannot have left yet: earliest is the next rising edge
          term_out_q[term_out_q.size()-1].kind = KEY_TAB[r].kind;
          term_out_q[term_out_q.size()-1].data = KEY_TAB[r].data;
          term_out_q[term_out_q.size()-1].len  = KEY_TAB[r].len;
        end
      end
    end

    // Random phases over capacities and handshake patterns
    run_phase(6'd32, IDLE_NONE, 300);
    run_phase(6'd0,  IDLE_SRC,  0);
    run_phase(6'd1,  IDLE_SNK,  0);
    run_phase(6'd63, IDLE_BOTH, 0);
    run_phase(6'd2,  IDLE_NONE, 0);
    run_phase(6'd31, IDLE_SRC,  0);
    run_phase(6'd8,  IDLE_SNK,  0);
    run_phase(CAP_W'($urandom_range(63)), IDLE_BOTH, 0);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
